[hw/rtl/drc_pkg.sv]
// ----------------------------------------------------------------------------
// drc_pkg
// Shared constants and types for the draw run coalescer.
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

   localparam int MAX_PARTS  = 65536;
   localparam int IDX_W      = $clog2(MAX_PARTS) + 1;
   localparam int HANDLE_W   = 32;
   localparam int MATNUM_W   = 16;
   localparam int PRIO_W     = 8;
   localparam int ALPHA_W    = 8;
   localparam int START_W    = 16;
   localparam int COUNT_W    = 17;
   localparam int MIN_FUSE   = 2;
   localparam int FIFO_DEPTH = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RUN_LENGTH   = 4'd0,
      CSR_OPAQUE_THRESHOLD = 4'd1
   } csr_index_type;

   // classified command as handed from the front to the back
   typedef struct packed {
      logic [HANDLE_W-1:0] mesh;
      logic [HANDLE_W-1:0] material;
      logic [HANDLE_W-1:0] texture;
      logic [MATNUM_W-1:0] material_number;
      logic [PRIO_W-1:0]   priority_level;
      logic                fusable;
      logic [START_W-1:0]  index;
      logic                dropped;
      logic                last;
   } cmd_type;

endpackage

`default_nettype wire

[hw/rtl/draw_run_coalescer.sv]
// ----------------------------------------------------------------------------
// draw_run_coalescer
// Fuses consecutive matching draw commands into instanced batches.
// ----------------------------------------------------------------------------
// Commands are numbered from 0 within a list; a run extends while the mesh,
// material, texture, material number and priority equal the run head's and
// both are opaque and unskinned. A closing run of at least min_run_length
// commands (which must be 2 or more) comes out as start index and count.
// One command is taken per cycle while the queue has room: the front numbers
// and classifies it in the cycle it is accepted, a two-entry queue follows,
// and the back compares it against the head keys and updates the run counter
// when it pops it. A batch appears on rsp_ the cycle after its closing command
// leaves the queue. Commands past index 65535 are dropped but their
// end_of_list flag still closes the list. Registers:
// index 0 min_run_length (reset 2), index 1 opaque_threshold (reset 255);
// csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module draw_run_coalescer
   import drc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [HANDLE_W-1:0]   req_mesh_handle,
   input  wire logic [HANDLE_W-1:0]   req_material_handle,
   input  wire logic [HANDLE_W-1:0]   req_texture_handle,
   input  wire logic [MATNUM_W-1:0]   req_material_number,
   input  wire logic [PRIO_W-1:0]     req_draw_priority,
   input  wire logic [ALPHA_W-1:0]    req_alpha_level,
   input  wire logic                  req_has_bone_palette,
   input  wire logic                  req_end_of_list,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [START_W-1:0]         rsp_batch_start,
   output logic [COUNT_W-1:0]         rsp_fused_count,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [COUNT_W-1:0] min_run_length_ff;
   logic [ALPHA_W-1:0] opaque_threshold_ff;

   logic    queue_full;
   logic    push;
   cmd_type front_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_length_ff   <= COUNT_W'(MIN_FUSE);
         opaque_threshold_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_RUN_LENGTH: begin
               min_run_length_ff <= csr_data[COUNT_W-1:0];
            end
            CSR_OPAQUE_THRESHOLD: begin
               opaque_threshold_ff <= csr_data[ALPHA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   drc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mesh_handle      (req_mesh_handle),
      .req_material_handle  (req_material_handle),
      .req_texture_handle   (req_texture_handle),
      .req_material_number  (req_material_number),
      .req_draw_priority    (req_draw_priority),
      .req_alpha_level      (req_alpha_level),
      .req_has_bone_palette (req_has_bone_palette),
      .req_end_of_list      (req_end_of_list),
      .opaque_threshold     (opaque_threshold_ff),
      .queue_full           (queue_full),
      .push                 (push),
      .cmd                  (front_cmd)
   );

   drc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   drc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (head_valid),
      .cmd             (head_cmd),
      .cmd_pop         (pop),
      .min_run_length  (min_run_length_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_batch_start (rsp_batch_start),
      .rsp_fused_count (rsp_fused_count)
   );

endmodule

`default_nettype wire

[hw/rtl/drc_front.sv]
// ----------------------------------------------------------------------------
// drc_front
// Accepts commands, numbers them within the list, marks overflow and
// fusability, and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_front
   import drc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [HANDLE_W-1:0] req_mesh_handle,
   input  wire logic [HANDLE_W-1:0] req_material_handle,
   input  wire logic [HANDLE_W-1:0] req_texture_handle,
   input  wire logic [MATNUM_W-1:0] req_material_number,
   input  wire logic [PRIO_W-1:0]   req_draw_priority,
   input  wire logic [ALPHA_W-1:0]  req_alpha_level,
   input  wire logic                req_has_bone_palette,
   input  wire logic                req_end_of_list,
   input  wire logic [ALPHA_W-1:0]  opaque_threshold,
   input  wire logic                queue_full,
   output logic                     push,
   output cmd_type                  cmd
);

   logic [IDX_W-1:0] next_index_ff;
   logic [IDX_W-1:0] next_index_in;
   logic             dropped;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign dropped   = next_index_ff >= IDX_W'(MAX_PARTS);

   always_comb begin
      cmd.mesh            = req_mesh_handle;
      cmd.material        = req_material_handle;
      cmd.texture         = req_texture_handle;
      cmd.material_number = req_material_number;
      cmd.priority_level  = req_draw_priority;
      cmd.fusable         = (req_alpha_level >= opaque_threshold) && !req_has_bone_palette;
      cmd.index           = next_index_ff[START_W-1:0];
      cmd.dropped         = dropped;
      cmd.last            = req_end_of_list;
   end

   always_comb begin
      next_index_in = next_index_ff;
      if (push) begin
         if (req_end_of_list) begin
            next_index_in = '0;
         end else if (!dropped) begin
            next_index_in = next_index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff <= '0;
      end else begin
         next_index_ff <= next_index_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/drc_queue.sv]
// ----------------------------------------------------------------------------
// drc_queue
// Short first-in first-out queue of classified commands between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_queue
   import drc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type          entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == CNT_W'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/drc_back.sv]
// ----------------------------------------------------------------------------
// drc_back
// Holds the open run's head keys, compares each command against them,
// extends or closes runs, and registers emitted batches.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_back
   import drc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire cmd_type            cmd,
   output logic                    cmd_pop,
   input  wire logic [COUNT_W-1:0] min_run_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [START_W-1:0]      rsp_batch_start,
   output logic [COUNT_W-1:0]      rsp_fused_count
);

   logic [HANDLE_W-1:0] head_mesh_ff;
   logic [HANDLE_W-1:0] head_material_ff;
   logic [HANDLE_W-1:0] head_texture_ff;
   logic [MATNUM_W-1:0] head_material_number_ff;
   logic [PRIO_W-1:0]   head_priority_ff;
   logic                head_fusable_ff;
   logic [START_W-1:0]  run_start_ff;
   logic [COUNT_W-1:0]  run_length_ff;
   logic [COUNT_W-1:0]  run_length_in;
   logic                run_open_ff;
   logic                run_open_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [START_W-1:0]  rsp_start_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                match;
   logic                open_new;
   logic                close_valid;
   logic [START_W-1:0]  close_start;
   logic [COUNT_W-1:0]  close_len;
   logic                emit;

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || rsp_ready);

   assign match = run_open_ff && head_fusable_ff && cmd.fusable
               && cmd.mesh == head_mesh_ff
               && cmd.material == head_material_ff
               && cmd.texture == head_texture_ff
               && cmd.material_number == head_material_number_ff
               && cmd.priority_level == head_priority_ff;

   assign open_new = !cmd.dropped && !match;

   always_comb begin
      close_valid   = 1'b0;
      close_start   = run_start_ff;
      close_len     = run_length_ff;
      run_length_in = run_length_ff;
      run_open_in   = run_open_ff;
      if (cmd_pop) begin
         if (!cmd.dropped) begin
            if (match) begin
               run_length_in = run_length_ff + COUNT_W'(1);
               if (cmd.last) begin
                  close_valid = 1'b1;
                  close_len   = run_length_ff + COUNT_W'(1);
               end
            end else begin
               close_valid   = run_open_ff;
               run_length_in = COUNT_W'(1);
               run_open_in   = 1'b1;
            end
         end else if (cmd.last) begin
            close_valid = run_open_ff;
         end
         if (cmd.last) begin
            run_open_in = 1'b0;
         end
      end
   end

   assign emit = close_valid && (min_run_length >= COUNT_W'(MIN_FUSE))
              && (close_len >= min_run_length);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_pop) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && open_new) begin
         head_mesh_ff            <= cmd.mesh;
         head_material_ff        <= cmd.material;
         head_texture_ff         <= cmd.texture;
         head_material_number_ff <= cmd.material_number;
         head_priority_ff        <= cmd.priority_level;
         head_fusable_ff         <= cmd.fusable;
         run_start_ff            <= cmd.index;
      end
      run_length_ff <= run_length_in;
      if (cmd_pop && emit) begin
         rsp_start_ff <= close_start;
         rsp_count_ff <= close_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_open_ff  <= run_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_batch_start = rsp_start_ff;
   assign rsp_fused_count = rsp_count_ff;

endmodule

`default_nettype wire

[hw/rtl/drc_checker.sv]
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks on the draw run coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_checker
   import drc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [START_W-1:0]    rsp_batch_start,
   input wire logic [COUNT_W-1:0]    rsp_fused_count,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready
);

   logic [COUNT_W:0] batch_end;

   assign batch_end = {2'b00, rsp_batch_start} + {1'b0, rsp_fused_count};

   // held batch stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_batch_start)
                                  && $stable(rsp_fused_count))
      else $error("batch changed while stalled");

   // a batch fuses at least two commands and stays inside the list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fused_count >= COUNT_W'(MIN_FUSE)
                    && batch_end <= (COUNT_W+1)'(MAX_PARTS))
      else $error("batch out of range");

   // reset empties the output and opens the input
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // right after reset, no batch can appear without a command having been taken before
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !$past(req_valid && req_ready) |-> !rsp_valid)
      else $error("batch without command");

   // configuration port never stalls
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind draw_run_coalescer drc_checker u_drc_checker (.*);

`default_nettype wire

[tb/batch_checker.sv]
// ----------------------------------------------------------------------------
// batch_checker
// Watches the command, batch and register channels of the draw run coalescer.
// Every accepted command is folded into a local copy of the run state, which
// queues the batches it should close; every accepted batch is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module batch_checker
   import drc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [HANDLE_W-1:0]   req_mesh_handle,
   input  wire logic [HANDLE_W-1:0]   req_material_handle,
   input  wire logic [HANDLE_W-1:0]   req_texture_handle,
   input  wire logic [MATNUM_W-1:0]   req_material_number,
   input  wire logic [PRIO_W-1:0]     req_draw_priority,
   input  wire logic [ALPHA_W-1:0]    req_alpha_level,
   input  wire logic                  req_has_bone_palette,
   input  wire logic                  req_end_of_list,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [START_W-1:0]    rsp_batch_start,
   input  wire logic [COUNT_W-1:0]    rsp_fused_count,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         pending_batches,
   output int                         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] count;
   } batch_type;

   batch_type           batches_due[$];

   logic [COUNT_W-1:0]  min_len;
   logic [ALPHA_W-1:0]  threshold;
   logic [HANDLE_W-1:0] lead_mesh;
   logic [HANDLE_W-1:0] lead_material;
   logic [HANDLE_W-1:0] lead_texture;
   logic [MATNUM_W-1:0] lead_number;
   logic [PRIO_W-1:0]   lead_prio;
   logic                lead_fusable;
   logic [START_W-1:0]  run_first;
   logic [COUNT_W-1:0]  run_count;
   logic [IDX_W-1:0]    list_index;
   logic                run_live;
   int                  errors;

   task automatic close_run();
      if (run_live && min_len >= MIN_FUSE && run_count >= min_len)
         batches_due.insert(batches_due.size(),
                            batch_type'{start: run_first, count: run_count});
      run_live = 1'b0;
   endtask

   task automatic fold_command(input logic [HANDLE_W-1:0] mesh, material, texture,
                               input logic [MATNUM_W-1:0] number,
                               input logic [PRIO_W-1:0] prio,
                               input logic [ALPHA_W-1:0] alpha,
                               input logic bones, last);
      logic fusable;
      fusable = (alpha >= threshold) && !bones;
      if (list_index < MAX_PARTS) begin
         if (run_live && lead_fusable && fusable && mesh == lead_mesh &&
             material == lead_material && texture == lead_texture &&
             number == lead_number && prio == lead_prio) begin
            run_count = run_count + 1'b1;
         end else begin
            close_run();
            lead_mesh     = mesh;
            lead_material = material;
            lead_texture  = texture;
            lead_number   = number;
            lead_prio     = prio;
            lead_fusable  = fusable;
            run_first     = list_index[START_W-1:0];
            run_count     = 1;
            run_live      = 1'b1;
         end
         list_index = list_index + 1'b1;
      end
      // a fresh head of one is never long enough, so closing it again is harmless
      if (last) begin
         close_run();
         list_index = '0;
      end
   endtask

   always @(posedge clock) begin
      batch_type want;
      if (reset) begin
         batches_due.delete();
         min_len       = MIN_FUSE;
         threshold     = '1;
         lead_mesh     = '0;
         lead_material = '0;
         lead_texture  = '0;
         lead_number   = '0;
         lead_prio     = '0;
         lead_fusable  = 1'b0;
         run_first     = '0;
         run_count     = '0;
         list_index    = '0;
         run_live      = 1'b0;
         errors        = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_RUN_LENGTH:   min_len = csr_data[COUNT_W-1:0];
               CSR_OPAQUE_THRESHOLD: threshold = csr_data[ALPHA_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (batches_due.size() == 0) begin
               $error("batch_start/fused_count: no batch expected, got %0d/%0d",
                      rsp_batch_start, rsp_fused_count);
               errors++;
            end else begin
               want = batches_due.pop_front();
               if (rsp_batch_start !== want.start) begin
                  $error("batch_start: expected %0d, got %0d", want.start, rsp_batch_start);
                  errors++;
               end
               if (rsp_fused_count !== want.count) begin
                  $error("fused_count: expected %0d, got %0d", want.count, rsp_fused_count);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            fold_command(req_mesh_handle, req_material_handle, req_texture_handle,
                         req_material_number, req_draw_priority, req_alpha_level,
                         req_has_bone_palette, req_end_of_list);
      end
      pending_batches <= batches_due.size();
      mismatch_count  <= errors;
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the draw run coalescer: directed runs, key breaks, opacity and
// skinning cases and register changes mid-run, then random command lists over
// several register settings with random gaps on both channels and a long
// batch stall that backs up the command input.
// ----------------------------------------------------------------------------
module testbench;
   import drc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [HANDLE_W-1:0] mesh;
      logic [HANDLE_W-1:0] material;
      logic [HANDLE_W-1:0] texture;
      logic [MATNUM_W-1:0] number;
      logic [PRIO_W-1:0]   prio;
      logic [ALPHA_W-1:0]  alpha;
      logic                bones;
      logic                last;
   } command_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [HANDLE_W-1:0]   req_mesh_handle;
   logic [HANDLE_W-1:0]   req_material_handle;
   logic [HANDLE_W-1:0]   req_texture_handle;
   logic [MATNUM_W-1:0]   req_material_number;
   logic [PRIO_W-1:0]     req_draw_priority;
   logic [ALPHA_W-1:0]    req_alpha_level;
   logic                  req_has_bone_palette;
   logic                  req_end_of_list;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [START_W-1:0]    rsp_batch_start;
   logic [COUNT_W-1:0]    rsp_fused_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    pending_batches;
   int                    mismatch_count;

   bit                    sender_calm;
   bit                    choke_request;
   int                    items_sent;
   logic [ALPHA_W-1:0]    cur_threshold;

   draw_run_coalescer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mesh_handle      (req_mesh_handle),
      .req_material_handle  (req_material_handle),
      .req_texture_handle   (req_texture_handle),
      .req_material_number  (req_material_number),
      .req_draw_priority    (req_draw_priority),
      .req_alpha_level      (req_alpha_level),
      .req_has_bone_palette (req_has_bone_palette),
      .req_end_of_list      (req_end_of_list),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_batch_start      (rsp_batch_start),
      .rsp_fused_count      (rsp_fused_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   batch_checker batch_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mesh_handle      (req_mesh_handle),
      .req_material_handle  (req_material_handle),
      .req_texture_handle   (req_texture_handle),
      .req_material_number  (req_material_number),
      .req_draw_priority    (req_draw_priority),
      .req_alpha_level      (req_alpha_level),
      .req_has_bone_palette (req_has_bone_palette),
      .req_end_of_list      (req_end_of_list),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_batch_start      (rsp_batch_start),
      .rsp_fused_count      (rsp_fused_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .pending_batches      (pending_batches),
      .mismatch_count       (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic command_type make_cmd(input logic [HANDLE_W-1:0] mesh, material, texture,
                                            input logic [MATNUM_W-1:0] number,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic [ALPHA_W-1:0] alpha,
                                            input logic bones, last);
      command_type c;
      c.mesh     = mesh;
      c.material = material;
      c.texture  = texture;
      c.number   = number;
      c.prio     = prio;
      c.alpha    = alpha;
      c.bones    = bones;
      c.last     = last;
      return c;
   endfunction

   function automatic command_type key_a(input logic [ALPHA_W-1:0] alpha,
                                         input logic bones, last);
      return make_cmd(32'h1234_5678, 32'h0bad_f00d, 32'h0000_00c3, 16'h0042, 8'h07,
                      alpha, bones, last);
   endfunction

   task automatic offer(input command_type c);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_mesh_handle      <= c.mesh;
      req_material_handle  <= c.material;
      req_texture_handle   <= c.texture;
      req_material_number  <= c.number;
      req_draw_priority    <= c.prio;
      req_alpha_level      <= c.alpha;
      req_has_bone_palette <= c.bones;
      req_end_of_list      <= c.last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_batches != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] min_len,
                            input logic [ALPHA_W-1:0] thr);
      drain();
      write_reg(CSR_MIN_RUN_LENGTH, min_len);
      write_reg(CSR_OPAQUE_THRESHOLD, thr);
      cur_threshold = thr;
   endtask

   // a list of runs over three key sets, some of them one bit apart, or at times a list of random commands
   task automatic random_list();
      command_type keys [3];
      command_type c;
      int segments;
      int len;
      int pick;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            c = make_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom_range(0, 7) == 0);
            offer(c);
         end
         return;
      end
      for (int k = 0; k < 3; k++) begin
         keys[k] = make_cmd($urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
         if (k > 0 && $urandom_range(0, 1) == 1) begin
            keys[k] = keys[0];
            case ($urandom_range(0, 4))
               0: keys[k].mesh     ^= 32'd1 << $urandom_range(0, 31);
               1: keys[k].material ^= 32'd1 << $urandom_range(0, 31);
               2: keys[k].texture  ^= 32'd1 << $urandom_range(0, 31);
               3: keys[k].number   ^= 16'd1 << $urandom_range(0, 15);
               default: keys[k].prio ^= 8'd1 << $urandom_range(0, 7);
            endcase
         end
      end
      segments = $urandom_range(1, 6);
      for (int s = 0; s < segments; s++) begin
         pick = $urandom_range(0, 2);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            c = keys[pick];
            case ($urandom_range(0, 9))
               0: c.alpha = $urandom;
               1: c.alpha = cur_threshold;
               2: c.alpha = cur_threshold - 1'b1;
               default: c.alpha = '1;
            endcase
            c.bones = ($urandom_range(0, 11) == 0);
            c.last  = (s == segments - 1) && (i == len - 1);
            offer(c);
         end
      end
   endtask

   // batch side: random holds, calm stretches and one long stall on request
   initial begin
      int wait_cycles;
      bit rsp_calm;
      rsp_calm = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (choke_request) begin
            choke_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         if ($urandom_range(0, 19) == 0)
            rsp_calm = !rsp_calm;
         wait_cycles = rsp_calm ? 0 : $urandom_range(0, 16);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      command_type c;
      int quota;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_mesh_handle      <= '0;
      req_material_handle  <= '0;
      req_texture_handle   <= '0;
      req_material_number  <= '0;
      req_draw_priority    <= '0;
      req_alpha_level      <= '0;
      req_has_bone_palette <= 1'b0;
      req_end_of_list      <= 1'b0;
      rsp_ready            <= 1'b0;
      csr_valid            <= 1'b0;
      csr_index            <= CSR_MIN_RUN_LENGTH;
      csr_data             <= '0;
      sender_calm   = 1'b0;
      choke_request = 1'b0;
      items_sent    = 0;
      cur_threshold = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // run of three closed by end of list
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b1));
      // head just below the threshold stands alone
      offer(key_a(8'hfe, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b1));
      // skinned head, then a run closed by a new head that ends the list
      offer(key_a(8'hff, 1'b1, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(make_cmd('1, '1, '1, '1, '1, '1, 1'b0, 1'b1));
      // all ones and all zero keys
      offer(make_cmd('1, '1, '1, '1, '1, '1, 1'b0, 1'b0));
      offer(make_cmd('1, '1, '1, '1, '1, '1, 1'b0, 1'b0));
      offer(make_cmd('0, '0, '0, '0, '0, '1, 1'b0, 1'b0));
      offer(make_cmd('0, '0, '0, '0, '0, '1, 1'b0, 1'b1));
      // each key alone breaks the run
      offer(key_a(8'hff, 1'b0, 1'b0));
      c = key_a(8'hff, 1'b0, 1'b0); c.prio     ^= 8'd1;  offer(c);
      c = key_a(8'hff, 1'b0, 1'b0); c.number   ^= 16'd1; offer(c);
      c = key_a(8'hff, 1'b0, 1'b0); c.texture  ^= 32'd1; offer(c);
      c = key_a(8'hff, 1'b0, 1'b0); c.material ^= 32'd1; offer(c);
      c = key_a(8'hff, 1'b0, 1'b1); c.mesh     ^= 32'd1; offer(c);
      // minimum length raised while a run is open
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b0));
      configure(3, 8'hff);
      offer(key_a(8'hff, 1'b0, 1'b1));
      // threshold lowered under a translucent head, which stays unfusable
      offer(key_a(8'd100, 1'b0, 1'b0));
      configure(2, 8'h00);
      offer(key_a(8'd100, 1'b0, 1'b0));
      offer(key_a(8'h00, 1'b0, 1'b1));

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(2, 8'hff);
            1: configure(3, 8'd128);
            2: configure(0, 8'h00);
            3: configure(1, 8'd200);
            4: begin
               configure(2, 8'h00);
               choke_request = 1'b1;
            end
            5: configure($urandom_range(2, 6), $urandom_range(0, 255));
            6: configure(4, 8'hff);
            default: configure($urandom_range(0, 8), $urandom_range(1, 254));
         endcase
         quota = items_sent + 200;
         while (items_sent < quota) begin
            sender_calm = (p == 4) || ($urandom_range(0, 5) == 0);
            random_list();
         end
      end

      // short run after the random lists
      configure(2, 8'hff);
      sender_calm = 1'b0;
      offer(key_a(8'hff, 1'b0, 1'b0));
      offer(key_a(8'hff, 1'b0, 1'b1));

      drain();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
hw/rtl/drc_pkg.sv
hw/rtl/drc_front.sv
hw/rtl/drc_queue.sv
hw/rtl/drc_back.sv
hw/rtl/draw_run_coalescer.sv
hw/rtl/drc_checker.sv
tb/batch_checker.sv
tb/testbench.sv
